// File: sv/dof_pkg.sv
`timescale 1ns / 1ps

package dof_pkg;

  // field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = SAMPLE_W + 1;
  localparam int DISP_W     = 32;
  localparam int SCALE_W    = 20;
  localparam int MASK_W     = 8;
  localparam int FORCE_W    = 32;
  localparam int NUMC_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int MAX_COMPONENTS_DEF = 4;

  // datapath widths
  localparam int GRAD_FRAC = 8;                 // gradient is Q.8
  localparam int GMAG_W    = 28;                // |g| < 2^28
  localparam int G_W       = GMAG_W + 1;
  localparam int GSQ_W     = 2 * GMAG_W;
  localparam int GD_W      = G_W + DISP_W;
  localparam int ITSQ_W    = 32;
  localparam int NUM_W     = 62;
  localparam int NUMMAG_W  = NUM_W - 1;
  localparam int NUMLO_W   = 31;
  localparam int NUMHI_W   = NUMMAG_W - NUMLO_W;
  localparam int DEN_W     = 59;
  localparam int SUM_W     = 48;
  localparam int PROD_W    = 88;
  localparam int QB_W      = 56;
  localparam int CNT_W     = 6;
  localparam int TERM_QBITS  = 35;
  localparam int FINAL_QBITS = 56;
  localparam int IT_SHIFT  = 24;
  localparam int DEN_SHIFT = 16;
  localparam int FIFO_DEPTH = 2;

  localparam logic [SCALE_W-1:0] GRAD_SCALE_RST = SCALE_W'(32768);
  localparam logic [MASK_W-1:0]  MASK_FULL      = MASK_W'(255);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAD_SCALE_X    = 3'd0,
    CFG_GRAD_SCALE_Y    = 3'd1,
    CFG_GRAD_SCALE_Z    = 3'd2,
    CFG_NUM_COMPONENTS  = 3'd3,
    CFG_MASK_ENABLE     = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MUL0,
    B_MUL1,
    B_TGO,
    B_TDIV,
    B_ACC,
    B_SCALE,
    B_FGO,
    B_FDIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
    logic [SCALE_W-1:0] scale_z;
    logic [NUMC_W-1:0]  num_comp;
    logic               mask_en;
  } dof_cfg_t;

  typedef struct packed {
    logic signed [G_W-1:0]   g_x;
    logic signed [G_W-1:0]   g_y;
    logic signed [G_W-1:0]   g_z;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
    logic                    nz;
    logic                    last;
    logic [MASK_W-1:0]       mask;
  } dof_item_t;

endpackage

// File: sv/dof_fifo.sv
`timescale 1ns / 1ps

module dof_fifo import dof_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  dof_item_t wdata,
  output logic      full,
  input  logic      pop,
  output dof_item_t rdata,
  output logic      empty
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  dof_item_t       mem [FIFO_DEPTH];
  logic [PW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule

// File: sv/dof_front.sv
`timescale 1ns / 1ps

module dof_front import dof_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dof_cfg_t                   cfg,
  input  logic                       push,
  output logic                       full,
  input  logic signed [SAMPLE_W-1:0] fixed_sample,
  input  logic signed [SAMPLE_W-1:0] moving_center,
  input  logic signed [SAMPLE_W-1:0] moving_x_prev,
  input  logic signed [SAMPLE_W-1:0] moving_x_next,
  input  logic signed [SAMPLE_W-1:0] moving_y_prev,
  input  logic signed [SAMPLE_W-1:0] moving_y_next,
  input  logic signed [SAMPLE_W-1:0] moving_z_prev,
  input  logic signed [SAMPLE_W-1:0] moving_z_next,
  input  logic signed [DISP_W-1:0]   disp_x,
  input  logic signed [DISP_W-1:0]   disp_y,
  input  logic signed [DISP_W-1:0]   disp_z,
  input  logic [MASK_W-1:0]          mask_weight,
  output logic                       q_push,
  output dof_item_t                  q_data,
  input  logic                       q_full
);

  localparam int NW  = $clog2(MAX_COMPONENTS + 1);
  localparam int CIW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  function automatic logic signed [G_W-1:0] grad_f(
    input logic signed [SAMPLE_W-1:0] nxt,
    input logic signed [SAMPLE_W-1:0] prv,
    input logic [SCALE_W-1:0]         scale
  );
    logic signed [DIFF_W-1:0]      d;
    logic [DIFF_W-1:0]             mag;
    logic [DIFF_W+SCALE_W-1:0]     p;
    logic [G_W-1:0]                pm;
    d   = DIFF_W'(nxt) - DIFF_W'(prv);
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    p   = (DIFF_W+SCALE_W)'(mag) * (DIFF_W+SCALE_W)'(scale);
    pm  = {1'b0, p[GRAD_FRAC+GMAG_W-1:GRAD_FRAC]};
    return d[DIFF_W-1] ? G_W'(-pm) : G_W'(pm);
  endfunction

  logic                  adv, acc;
  logic                  v1_r, v2_r, v3_r;
  logic [CIW-1:0]        cidx_r;
  logic [NW-1:0]         n_eff;
  logic                  is_last;

  logic signed [G_W-1:0]    g1_r [3];
  logic signed [DISP_W-1:0] d1_r [3];
  logic signed [DIFF_W-1:0] it1_r;
  logic [MASK_W-1:0]        mask1_r;
  logic                     last1_r;

  logic signed [G_W-1:0]    g2_r [3];
  logic [GSQ_W-1:0]         gsq2_r [3];
  logic signed [GD_W-1:0]   gd2_r [3];
  logic [ITSQ_W-1:0]        itsq2_r;
  logic signed [DIFF_W-1:0] it2_r;
  logic                     nz2_r;
  logic [MASK_W-1:0]        mask2_r;
  logic                     last2_r;

  dof_item_t                item3_r;

  logic [GMAG_W-1:0]        ag [3];
  logic [DIFF_W-1:0]        ait;
  logic [GSQ_W+1:0]         n2;
  logic signed [NUM_W-1:0]  num;

  assign adv    = !v3_r || !q_full;
  assign full   = !adv;
  assign acc    = push && adv;
  assign q_push = v3_r;
  assign q_data = item3_r;

  assign n_eff = (cfg.num_comp == '0) ? NW'(1) :
                 ((32'(cfg.num_comp) > MAX_COMPONENTS) ? NW'(MAX_COMPONENTS) :
                  NW'(cfg.num_comp));
  assign is_last = (32'(cidx_r) + 1 >= 32'(n_eff));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ag[k] = g1_r[k][G_W-1] ? GMAG_W'(-g1_r[k]) : GMAG_W'(g1_r[k]);
    end
    ait = it1_r[DIFF_W-1] ? DIFF_W'(-it1_r) : DIFF_W'(it1_r);
    n2  = (GSQ_W+2)'(gsq2_r[0]) + (GSQ_W+2)'(gsq2_r[1]) + (GSQ_W+2)'(gsq2_r[2]);
    num = NUM_W'(gd2_r[0]) + NUM_W'(gd2_r[1]) + NUM_W'(gd2_r[2]) +
          (NUM_W'(it2_r) <<< IT_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      cidx_r <= '0;
    end else begin
      if (adv) begin
        v1_r <= acc;
        v2_r <= v1_r;
        v3_r <= v2_r;
      end
      if (acc) begin
        cidx_r <= is_last ? '0 : cidx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_r[0] <= grad_f(moving_x_next, moving_x_prev, cfg.scale_x);
      g1_r[1] <= grad_f(moving_y_next, moving_y_prev, cfg.scale_y);
      g1_r[2] <= grad_f(moving_z_next, moving_z_prev, cfg.scale_z);
      d1_r[0] <= disp_x;
      d1_r[1] <= disp_y;
      d1_r[2] <= disp_z;
      it1_r   <= DIFF_W'(moving_center) - DIFF_W'(fixed_sample);
      mask1_r <= mask_weight;
      last1_r <= is_last;

      for (int k = 0; k < 3; k++) begin
        g2_r[k]   <= g1_r[k];
        gsq2_r[k] <= GSQ_W'(ag[k]) * GSQ_W'(ag[k]);
        gd2_r[k]  <= GD_W'(g1_r[k]) * GD_W'(d1_r[k]);
      end
      itsq2_r <= ITSQ_W'(ait) * ITSQ_W'(ait);
      it2_r   <= it1_r;
      nz2_r   <= (g1_r[0] != '0) || (g1_r[1] != '0) || (g1_r[2] != '0);
      mask2_r <= mask1_r;
      last2_r <= last1_r;

      item3_r.g_x  <= g2_r[0];
      item3_r.g_y  <= g2_r[1];
      item3_r.g_z  <= g2_r[2];
      item3_r.num  <= num;
      item3_r.den  <= DEN_W'(n2) + (DEN_W'(itsq2_r) << DEN_SHIFT);
      item3_r.nz   <= nz2_r;
      item3_r.last <= last2_r;
      item3_r.mask <= mask2_r;
    end
  end

endmodule

// File: sv/dof_div.sv
`timescale 1ns / 1ps

module dof_div import dof_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              final_mode,
  input  logic [PROD_W-1:0] dividend [3],
  input  logic [DEN_W-1:0]  divisor,
  output logic              done,
  output logic [QB_W-1:0]   quot [3]
);

  logic [DEN_W-1:0] div_r;
  logic [DEN_W-1:0] rem_r [3];
  logic [QB_W-1:0]  sh_r  [3];
  logic [QB_W-1:0]  q_r   [3];
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   t  [3];
  logic             ge [3];

  assign done = done_r;
  assign quot = q_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]  = {rem_r[k], sh_r[k][QB_W-1]};
      ge[k] = (t[k] >= {1'b0, div_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= final_mode ? CNT_W'(FINAL_QBITS) : CNT_W'(TERM_QBITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per lane per cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      for (int k = 0; k < 3; k++) begin
        q_r[k] <= '0;
        if (final_mode) begin
          rem_r[k] <= '0;
          sh_r[k]  <= dividend[k][QB_W-1:0];
        end else begin
          rem_r[k] <= DEN_W'(dividend[k][PROD_W-1:TERM_QBITS]);
          sh_r[k]  <= {dividend[k][TERM_QBITS-1:0], (QB_W-TERM_QBITS)'(0)};
        end
      end
    end else if (busy_r) begin
      for (int k = 0; k < 3; k++) begin
        rem_r[k] <= ge[k] ? DEN_W'(t[k] - {1'b0, div_r}) : t[k][DEN_W-1:0];
        sh_r[k]  <= {sh_r[k][QB_W-2:0], 1'b0};
        q_r[k]   <= {q_r[k][QB_W-2:0], ge[k]};
      end
    end
  end

endmodule

// File: sv/dof_back.sv
`timescale 1ns / 1ps

module dof_back import dof_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dof_cfg_t                  cfg,
  input  dof_item_t                 q_data,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic signed [FORCE_W-1:0] force_x,
  output logic signed [FORCE_W-1:0] force_y,
  output logic signed [FORCE_W-1:0] force_z
);

  localparam int NW = $clog2(MAX_COMPONENTS + 1);

  function automatic logic [FORCE_W-1:0] sat_f(input logic neg, input logic [QB_W-1:0] q);
    logic [FORCE_W-1:0] r;
    if (neg) begin
      r = (q > QB_W'(64'h8000_0000)) ? {1'b1, (FORCE_W-1)'(0)} : FORCE_W'(~q[FORCE_W-1:0] + 1'b1);
    end else begin
      r = (q > QB_W'(64'h7FFF_FFFF)) ? {1'b0, {(FORCE_W-1){1'b1}}} : q[FORCE_W-1:0];
    end
    return r;
  endfunction

  back_state_t st_r, st_nxt;
  dof_item_t   item_r;

  logic signed [SUM_W-1:0]  sum_r [3];
  logic [PROD_W-1:0]        prod_r [3];
  logic [NUMLO_W+GMAG_W-1:0] pp_r [3];
  logic                     fneg_r [3];
  logic [FORCE_W-1:0]       f_r [3];
  logic                     out_valid_r;

  logic signed [G_W-1:0]    g [3];
  logic [GMAG_W-1:0]        ag [3];
  logic [NUMMAG_W-1:0]      anum;
  logic [NUMLO_W-1:0]       mop;
  logic [NUMLO_W+GMAG_W-1:0] mres [3];
  logic [SUM_W-1:0]         smag [3];
  logic [MASK_W-1:0]        mval;
  logic [NW-1:0]            n_eff;
  logic [DEN_W-1:0]         divisor;
  logic                     div_start, div_final, div_done;
  logic [QB_W-1:0]          dq [3];
  logic                     tneg [3];
  logic [SUM_W-1:0]         q48 [3];
  logic                     out_wr;

  assign g[0] = item_r.g_x;
  assign g[1] = item_r.g_y;
  assign g[2] = item_r.g_z;

  assign n_eff = (cfg.num_comp == '0) ? NW'(1) :
                 ((32'(cfg.num_comp) > MAX_COMPONENTS) ? NW'(MAX_COMPONENTS) :
                  NW'(cfg.num_comp));
  assign mval  = cfg.mask_en ? item_r.mask : MASK_FULL;
  assign anum  = item_r.num[NUM_W-1] ? NUMMAG_W'(-item_r.num) : NUMMAG_W'(item_r.num);
  assign mop   = (st_r == B_MUL0) ? anum[NUMLO_W-1:0] : NUMLO_W'(anum[NUMMAG_W-1:NUMLO_W]);
  assign divisor = div_final ? DEN_W'(n_eff) * DEN_W'(MASK_FULL) : item_r.den;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ag[k]   = g[k][G_W-1] ? GMAG_W'(-g[k]) : GMAG_W'(g[k]);
      mres[k] = (NUMLO_W+GMAG_W)'(ag[k]) * (NUMLO_W+GMAG_W)'(mop);
      smag[k] = sum_r[k][SUM_W-1] ? SUM_W'(-sum_r[k]) : SUM_W'(sum_r[k]);
      tneg[k] = (g[k][G_W-1] == item_r.num[NUM_W-1]);
      q48[k]  = dq[k][SUM_W-1:0];
    end
  end

  dof_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (div_start),
    .final_mode (div_final),
    .dividend   (prod_r),
    .divisor    (divisor),
    .done       (div_done),
    .quot       (dq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    q_pop     = 1'b0;
    div_start = 1'b0;
    div_final = 1'b0;
    out_wr    = 1'b0;
    unique case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          st_nxt = q_data.nz ? B_MUL0 : B_ACC;
        end
      end
      B_MUL0: st_nxt = B_MUL1;
      B_MUL1: st_nxt = B_TGO;
      B_TGO: begin
        div_start = 1'b1;
        st_nxt    = B_TDIV;
      end
      B_TDIV: begin
        if (div_done) begin
          st_nxt = B_ACC;
        end
      end
      B_ACC: st_nxt = item_r.last ? B_SCALE : B_IDLE;
      B_SCALE: st_nxt = B_FGO;
      B_FGO: begin
        div_start = 1'b1;
        div_final = 1'b1;
        st_nxt    = B_FDIV;
      end
      B_FDIV: begin
        div_final = 1'b1;
        if (div_done) begin
          st_nxt = B_OUT;
        end
      end
      B_OUT: begin
        div_final = 1'b1;
        // hold until the output slot frees
        if (!out_valid_r || out_pop) begin
          out_wr = 1'b1;
          st_nxt = B_IDLE;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      if (st_r == B_ACC && item_r.nz) begin
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= tneg[k] ? sum_r[k] - q48[k] : sum_r[k] + q48[k];
        end
      end else if (st_r == B_SCALE) begin
        for (int k = 0; k < 3; k++) begin
          sum_r[k] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_data;
    end
    for (int k = 0; k < 3; k++) begin
      if (st_r == B_MUL0) begin
        pp_r[k] <= mres[k];
      end
      if (st_r == B_MUL1) begin
        prod_r[k] <= PROD_W'(pp_r[k]) + (PROD_W'(mres[k]) << NUMLO_W);
      end else if (st_r == B_SCALE) begin
        prod_r[k] <= PROD_W'(smag[k]) * PROD_W'(mval);
        fneg_r[k] <= sum_r[k][SUM_W-1];
      end
      if (out_wr) begin
        f_r[k] <= sat_f(fneg_r[k], dq[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_empty = !out_valid_r;
  assign force_x   = f_r[0];
  assign force_y   = f_r[1];
  assign force_z   = f_r[2];

`ifndef ASSERT_OFF
  a_sum_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SCALE) |=> (sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("sums not cleared after voxel");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == B_TDIV || st_r == B_FDIV))
    else $error("divider finished outside a wait state");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_pop) |=> (out_valid_r && $stable(f_r[0]) && $stable(f_r[1])))
    else $error("waiting result lost or changed");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_OUT && out_wr) |=> (st_r == B_IDLE && out_valid_r))
    else $error("result write did not land");
`endif

endmodule

// File: sv/demons_optical_flow_force_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                  Beat accepted when
// input     in_push/in_full, in_<fields>           in_push && !in_full
// result    out_pop/out_empty, out_force_x/y/z     out_pop && !out_empty
// config    cfg_we, cfg_index, cfg_wdata           cfg_we
//
// Front pipeline takes one beat per cycle while in_full is low, into a two-entry queue.
// Back end: a component with a nonzero gradient passes B_MUL0, B_MUL1 and a 35-step divide
// before it is accumulated; one with a zero gradient goes straight to B_ACC. The last component of
// a voxel adds B_SCALE and the 56-step scaling divide. The shared serial divider sets the rate.
// Reset is synchronous, active low; the result register lets the back end run on while a
// result waits, and in_full rises when the last front stage holds a beat and the queue is full.

module demons_optical_flow_force_unit import dof_pkg::*; #(
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_fixed_sample,
  input  logic signed [SAMPLE_W-1:0] in_moving_center,
  input  logic signed [SAMPLE_W-1:0] in_moving_x_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_x_next,
  input  logic signed [SAMPLE_W-1:0] in_moving_y_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_y_next,
  input  logic signed [SAMPLE_W-1:0] in_moving_z_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_z_next,
  input  logic signed [DISP_W-1:0]   in_disp_x,
  input  logic signed [DISP_W-1:0]   in_disp_y,
  input  logic signed [DISP_W-1:0]   in_disp_z,
  input  logic [MASK_W-1:0]          in_mask_weight,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [FORCE_W-1:0]  out_force_x,
  output logic signed [FORCE_W-1:0]  out_force_y,
  output logic signed [FORCE_W-1:0]  out_force_z
);

  dof_cfg_t  cfg_r;
  dof_item_t fq_wdata, fq_rdata;
  logic      fq_push, fq_full, fq_pop, fq_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_x  <= GRAD_SCALE_RST;
      cfg_r.scale_y  <= GRAD_SCALE_RST;
      cfg_r.scale_z  <= GRAD_SCALE_RST;
      cfg_r.num_comp <= NUMC_W'(1);
      cfg_r.mask_en  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRAD_SCALE_X:   cfg_r.scale_x  <= cfg_wdata[SCALE_W-1:0];
        CFG_GRAD_SCALE_Y:   cfg_r.scale_y  <= cfg_wdata[SCALE_W-1:0];
        CFG_GRAD_SCALE_Z:   cfg_r.scale_z  <= cfg_wdata[SCALE_W-1:0];
        CFG_NUM_COMPONENTS: cfg_r.num_comp <= cfg_wdata[NUMC_W-1:0];
        CFG_MASK_ENABLE:    cfg_r.mask_en  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  dof_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (in_push),
    .full          (in_full),
    .fixed_sample  (in_fixed_sample),
    .moving_center (in_moving_center),
    .moving_x_prev (in_moving_x_prev),
    .moving_x_next (in_moving_x_next),
    .moving_y_prev (in_moving_y_prev),
    .moving_y_next (in_moving_y_next),
    .moving_z_prev (in_moving_z_prev),
    .moving_z_next (in_moving_z_next),
    .disp_x        (in_disp_x),
    .disp_y        (in_disp_y),
    .disp_z        (in_disp_z),
    .mask_weight   (in_mask_weight),
    .q_push        (fq_push),
    .q_data        (fq_wdata),
    .q_full        (fq_full)
  );

  dof_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  dof_back #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_data    (fq_rdata),
    .q_empty   (fq_empty),
    .q_pop     (fq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .force_x   (out_force_x),
    .force_y   (out_force_y),
    .force_z   (out_force_z)
  );

endmodule

// File: dv/demons_force_checker.sv
`timescale 1ns / 1ps

module demons_force_checker import dof_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                       in_push,
  input  logic                       in_full,
  input  logic signed [SAMPLE_W-1:0] in_fixed_sample,
  input  logic signed [SAMPLE_W-1:0] in_moving_center,
  input  logic signed [SAMPLE_W-1:0] in_moving_x_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_x_next,
  input  logic signed [SAMPLE_W-1:0] in_moving_y_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_y_next,
  input  logic signed [SAMPLE_W-1:0] in_moving_z_prev,
  input  logic signed [SAMPLE_W-1:0] in_moving_z_next,
  input  logic signed [DISP_W-1:0]   in_disp_x,
  input  logic signed [DISP_W-1:0]   in_disp_y,
  input  logic signed [DISP_W-1:0]   in_disp_z,
  input  logic [MASK_W-1:0]          in_mask_weight,
  input  logic                       out_empty,
  input  logic                       out_pop,
  input  logic signed [FORCE_W-1:0]  out_force_x,
  input  logic signed [FORCE_W-1:0]  out_force_y,
  input  logic signed [FORCE_W-1:0]  out_force_z,
  output int                         fail_count,
  output int                         forces_pending,
  output int                         forces_seen
);

  typedef logic signed [127:0] wide_t;

  logic [SCALE_W-1:0]        scale_x, scale_y, scale_z;
  logic [NUMC_W-1:0]         num_comp;
  logic                      mask_en;
  int unsigned               comp_idx;
  logic signed [SUM_W-1:0]   sum_x, sum_y, sum_z;
  logic [3*FORCE_W-1:0]      force_q[$];

  function automatic wide_t grad_of(input logic signed [SAMPLE_W-1:0] nxt,
                                    input logic signed [SAMPLE_W-1:0] prv,
                                    input logic [SCALE_W-1:0] scale);
    wide_t d, mag, p;
    d   = wide_t'(nxt) - wide_t'(prv);
    mag = (d < 0) ? -d : d;
    p   = (mag * $signed({108'd0, scale})) >>> GRAD_FRAC;
    return (d < 0) ? -p : p;
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat_force(input wide_t v);
    if (v > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -wide_t'(64'sh80000000)) return 32'sh80000000;
    return v[FORCE_W-1:0];
  endfunction

  task automatic predict_beat();
    wide_t gx, gy, gz, n2, it, den, num, m, dv;
    int unsigned n;
    gx = grad_of(in_moving_x_next, in_moving_x_prev, scale_x);
    gy = grad_of(in_moving_y_next, in_moving_y_prev, scale_y);
    gz = grad_of(in_moving_z_next, in_moving_z_prev, scale_z);
    n2 = gx * gx + gy * gy + gz * gz;
    if (n2 > 0) begin
      it  = wide_t'(in_moving_center) - wide_t'(in_fixed_sample);
      den = n2 + it * it * 65536;
      num = gx * wide_t'(in_disp_x) + gy * wide_t'(in_disp_y) + gz * wide_t'(in_disp_z)
            + it * 16777216;
      // signed divide truncates toward zero, as the force terms do
      sum_x = sum_x + SUM_W'(-(gx * num) / den);
      sum_y = sum_y + SUM_W'(-(gy * num) / den);
      sum_z = sum_z + SUM_W'(-(gz * num) / den);
    end
    n = num_comp;
    if (n < 1) n = 1;
    if (n > MAX_COMPONENTS_DEF) n = MAX_COMPONENTS_DEF;
    if (comp_idx + 1 < n) begin
      comp_idx++;
    end else begin
      m  = mask_en ? wide_t'({1'b0, in_mask_weight}) : 255;
      dv = n * 255;
      force_q.push_back({sat_force(wide_t'(sum_x) * m / dv),
                         sat_force(wide_t'(sum_y) * m / dv),
                         sat_force(wide_t'(sum_z) * m / dv)});
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      comp_idx = 0;
    end
  endtask

  task automatic check_force(input string axis, input logic signed [FORCE_W-1:0] exp_v,
                             input logic signed [FORCE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t force_%s mismatch: expected %0d actual %0d", $time, axis, exp_v, act_v);
    end
  endtask

  initial begin
    fail_count = 0;
    forces_seen = 0;
    forces_pending = 0;
  end

  // sample half a cycle ahead of the edge that takes the beat
  always @(negedge clk) begin
    if (!rst_n) begin
      scale_x  = GRAD_SCALE_RST;
      scale_y  = GRAD_SCALE_RST;
      scale_z  = GRAD_SCALE_RST;
      num_comp = NUMC_W'(1);
      mask_en  = 1'b0;
      comp_idx = 0;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      force_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRAD_SCALE_X:   scale_x  = cfg_wdata[SCALE_W-1:0];
          CFG_GRAD_SCALE_Y:   scale_y  = cfg_wdata[SCALE_W-1:0];
          CFG_GRAD_SCALE_Z:   scale_z  = cfg_wdata[SCALE_W-1:0];
          CFG_NUM_COMPONENTS: num_comp = cfg_wdata[NUMC_W-1:0];
          CFG_MASK_ENABLE:    mask_en  = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_beat();
      if (out_pop && !out_empty) begin
        forces_seen++;
        if (force_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected force beat: expected none actual %0d %0d %0d",
                   $time, out_force_x, out_force_y, out_force_z);
        end else begin
          logic [3*FORCE_W-1:0] f;
          f = force_q.pop_front();
          check_force("x", f[3*FORCE_W-1:2*FORCE_W], out_force_x);
          check_force("y", f[2*FORCE_W-1:FORCE_W], out_force_y);
          check_force("z", f[FORCE_W-1:0], out_force_z);
        end
      end
    end
    forces_pending = force_q.size();
  end

endmodule

// File: dv/demons_optical_flow_force_unit_tb.sv
`timescale 1ns / 1ps

module demons_optical_flow_force_unit_tb;
  import dof_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] fixed_s;
    logic signed [SAMPLE_W-1:0] center;
    logic signed [SAMPLE_W-1:0] xp, xn, yp, yn, zp, zn;
    logic signed [DISP_W-1:0]   dx, dy, dz;
    logic [MASK_W-1:0]          mask;
  } voxel_t;

  localparam int N_ITEMS = 1450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [SAMPLE_W-1:0] in_fixed_sample = '0, in_moving_center = '0;
  logic signed [SAMPLE_W-1:0] in_moving_x_prev = '0, in_moving_x_next = '0;
  logic signed [SAMPLE_W-1:0] in_moving_y_prev = '0, in_moving_y_next = '0;
  logic signed [SAMPLE_W-1:0] in_moving_z_prev = '0, in_moving_z_next = '0;
  logic signed [DISP_W-1:0] in_disp_x = '0, in_disp_y = '0, in_disp_z = '0;
  logic [MASK_W-1:0] in_mask_weight = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic signed [FORCE_W-1:0] out_force_x, out_force_y, out_force_z;

  int fail_count, forces_pending, forces_seen;
  int items_sent = 0;
  int phases_run = 0;
  bit no_idle = 1'b0;
  logic full_seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  demons_optical_flow_force_unit u_top (.*);

  demons_force_checker u_chk (.*);

  always @(negedge clk) full_seen = in_full;

  always @(posedge clk) out_pop <= rst_n && (no_idle || $urandom_range(99) >= 9);

  task automatic set_config(input logic [SCALE_W-1:0] sx, input logic [SCALE_W-1:0] sy,
                            input logic [SCALE_W-1:0] sz, input logic [NUMC_W-1:0] nc,
                            input logic me);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GRAD_SCALE_X;    cfg_wdata <= CFG_DATA_W'(sx); @(posedge clk);
    cfg_index <= CFG_GRAD_SCALE_Y;    cfg_wdata <= CFG_DATA_W'(sy); @(posedge clk);
    cfg_index <= CFG_GRAD_SCALE_Z;    cfg_wdata <= CFG_DATA_W'(sz); @(posedge clk);
    cfg_index <= CFG_NUM_COMPONENTS;  cfg_wdata <= CFG_DATA_W'(nc); @(posedge clk);
    cfg_index <= CFG_MASK_ENABLE;     cfg_wdata <= CFG_DATA_W'(me); @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // leave enough cycles for a partial voxel still in the back end
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (forces_pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic push_voxel(input voxel_t v);
    while (!no_idle && $urandom_range(99) < 9) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_fixed_sample <= v.fixed_s;  in_moving_center <= v.center;
    in_moving_x_prev <= v.xp;      in_moving_x_next <= v.xn;
    in_moving_y_prev <= v.yp;      in_moving_y_next <= v.yn;
    in_moving_z_prev <= v.zp;      in_moving_z_next <= v.zn;
    in_disp_x <= v.dx;  in_disp_y <= v.dy;  in_disp_z <= v.dz;
    in_mask_weight <= v.mask;
    @(posedge clk);
    while (full_seen) @(posedge clk);
    items_sent++;
  endtask

  function automatic voxel_t flat_voxel(input logic signed [SAMPLE_W-1:0] c);
    voxel_t v;
    v = '0;
    v.center = c;
    v.xp = c; v.xn = c; v.yp = c; v.yn = c; v.zp = c; v.zn = c;
    return v;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] near(input logic signed [SAMPLE_W-1:0] c,
                                                      input int span);
    int r;
    r = int'(c) + $urandom_range(2 * span) - span;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return SAMPLE_W'(r);
  endfunction

  function automatic voxel_t rand_voxel();
    voxel_t v;
    int mode;
    mode = $urandom_range(9);
    if (mode < 3) begin
      v = voxel_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    8'($urandom)});
    end else begin
      v.center  = near(16'sd0, 20000);
      v.fixed_s = near(v.center, 1500);
      v.xp = near(v.center, 400);  v.xn = near(v.center, 400);
      v.yp = near(v.center, 400);  v.yn = near(v.center, 400);
      v.zp = near(v.center, 400);  v.zn = near(v.center, 400);
      v.dx = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      v.dy = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      v.dz = $signed($urandom_range(2 ** 22)) - (2 ** 21);
      v.mask = MASK_W'($urandom);
      // flat neighborhood: zero gradient
      if (mode == 3) begin
        v.xp = v.center; v.xn = v.center; v.yp = v.center;
        v.yn = v.center; v.zp = v.center; v.zn = v.center;
      end
    end
    return v;
  endfunction

  function automatic logic [SCALE_W-1:0] rand_scale();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return SCALE_W'($urandom);
      3: return SCALE_W'($urandom_range(255));
      default: return SCALE_W'($urandom_range(2048, 131072));
    endcase
  endfunction

  initial begin
    voxel_t v;
    int n_phase;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero beat, both extreme corners, mixed signs
    push_voxel('0);
    v.fixed_s = 16'sh8000; v.center = 16'sh7fff;
    v.xp = 16'sh8000; v.xn = 16'sh7fff; v.yp = 16'sh8000; v.yn = 16'sh7fff;
    v.zp = 16'sh8000; v.zn = 16'sh7fff;
    v.dx = 32'sh7fffffff; v.dy = 32'sh7fffffff; v.dz = 32'sh7fffffff; v.mask = 8'hff;
    push_voxel(v);
    v = '1;
    v.fixed_s = 16'sh7fff; v.center = 16'sh8000;
    v.xp = 16'sh7fff; v.xn = 16'sh8000; v.yp = 16'sh7fff; v.yn = 16'sh8000;
    v.zp = 16'sh7fff; v.zn = 16'sh8000;
    v.dx = 32'sh80000000; v.dy = 32'sh80000000; v.dz = 32'sh80000000;
    push_voxel(v);
    push_voxel(flat_voxel(16'sh7fff));
    v = flat_voxel(16'sd100);
    v.xn = 16'sd101; v.yp = 16'sd99; v.fixed_s = 16'sd90; v.dx = 32'sh00010000;
    push_voxel(v);
    drain();

    // small scales: unit differences truncate to a zero gradient
    set_config(20'd255, 20'd100, 20'd1, 3'd0, 1'b1);
    push_voxel(v);
    v.zn = 16'sd300; v.mask = 8'd0;
    push_voxel(v);
    drain();

    // full scales, mask on, count above the maximum
    set_config('1, '1, '1, 3'd7, 1'b1);
    v = rand_voxel(); v.mask = 8'd0;   push_voxel(v);
    v = rand_voxel(); v.mask = 8'd255; push_voxel(v);
    v = rand_voxel(); v.mask = 8'd128; push_voxel(v);
    v = rand_voxel(); v.mask = 8'd255; push_voxel(v);
    drain();

    // lower the count in the middle of a voxel
    set_config(20'd32768, 20'd65536, 20'd16384, 3'd4, 1'b0);
    push_voxel(rand_voxel());
    push_voxel(rand_voxel());
    drain();
    set_config(20'd32768, 20'd65536, 20'd16384, 3'd2, 1'b0);
    push_voxel(rand_voxel());
    push_voxel(rand_voxel());
    drain();

    while (items_sent < N_ITEMS) begin
      set_config(rand_scale(), rand_scale(), rand_scale(), 3'($urandom_range(7)),
                 1'($urandom));
      phases_run++;
      n_phase = $urandom_range(60, 220);
      if (n_phase > N_ITEMS - items_sent) n_phase = N_ITEMS - items_sent;
      no_idle = (phases_run == 4);
      repeat (n_phase) push_voxel(rand_voxel());
      no_idle = 1'b0;
      drain();
    end

    drain();
    $display("covered %0d voxel beats over %0d random phases, %0d force beats checked",
             items_sent, phases_run, forces_seen);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d force beats outstanding", forces_pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
